@@ rtl/spf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_pkg
// shared types and constants for the sieve prime factorizer
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int VALUE_BITS_DEF  = 16;
    localparam int PRIME_SLOTS_DEF = 6542;

    localparam int IN_W        = 16;
    localparam int FACTOR_W    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

    typedef logic [IN_W-1:0]     value_t;
    typedef logic [FACTOR_W-1:0] factor_t;

    // divider control between sequencer and shared unit
    typedef struct packed {
        logic   start;
        value_t dividend;
        value_t divisor;
    } div_req_t;

    typedef struct packed {
        logic   done;
        value_t quotient;
        value_t remainder;
    } div_rsp_t;

endpackage

@@ rtl/spf_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_in_if
// request channel carrying one value to factor
// ----------------------------------------------------------------------------
interface spf_in_if
    import spf_pkg::*;
    ();
    logic   valid;
    logic   ready;
    value_t value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

@@ rtl/spf_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_out_if
// result channel carrying one prime factor with its flags
// ----------------------------------------------------------------------------
interface spf_out_if
    import spf_pkg::*;
    ();
    logic    valid;
    logic    ready;
    factor_t factor;
    logic    last;
    logic    invalid;

    modport source (output valid, output factor, output last, output invalid, input ready);
    modport sink   (input valid, input factor, input last, input invalid, output ready);
endinterface

@@ rtl/spf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module spf_ram
    import spf_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/spf_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module spf_divider
    import spf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CW = $clog2(IN_W + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    value_t          quo_reg, quo_next;
    value_t          rem_reg, rem_next;
    value_t          dvs_reg, dvs_next;
    logic [IN_W:0]   trial;
    logic [IN_W:0]   shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[IN_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(IN_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit into the partial remainder
            if (!trial[IN_W])
            begin
                rem_next = trial[IN_W-1:0];
                quo_next = {quo_reg[IN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[IN_W-1:0];
                quo_next = {quo_reg[IN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ rtl/sieve_prime_factorizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sieve_prime_factorizer_core
// prime factorization by trial division over a sieve-built prime table
// ----------------------------------------------------------------------------
// After reset the block clears a 2^VALUE_BITS entry composite map, sieves it,
// and scans it once more (a read and a test per entry) to build an ascending
// prime table; no request is taken until that is done. Each request then
// walks the table one prime at a time: a table read, a square check and,
// where the square does not exceed the remaining value, a 16-step pass of
// the shared restoring divider. A value takes longest when it is a 16-bit
// prime, which runs through every table prime below 256; how long a value
// takes is set by how many primes are tried before one squares past the
// remaining value. Result back-pressure adds its own wait. Factors come out
// ascending with repeats, the final one flagged last; 0 and 1 give one result
// flagged invalid.
module sieve_prime_factorizer_core
    import spf_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int PRIME_SLOTS = PRIME_SLOTS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    spf_in_if.sink    items,
    spf_out_if.source results
);

    localparam int MAP_DEPTH = 2 ** VALUE_BITS;
    localparam int IW = VALUE_BITS + 1;              // sweep counter
    localparam int HB = (VALUE_BITS + 1) / 2 + 1;    // sieve base
    localparam int JW = 2 * HB;                      // sieve multiple
    localparam int TW = $clog2(PRIME_SLOTS + 1);     // table count
    localparam int AW = $clog2(PRIME_SLOTS);         // table address

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_SV_SQ   = 13'b0000000000010,
        S_SV_TEST = 13'b0000000000100,
        S_SV_MARK = 13'b0000000001000,
        S_CL_RD   = 13'b0000000010000,
        S_CL_TEST = 13'b0000000100000,
        S_IDLE    = 13'b0000001000000,
        S_LOAD    = 13'b0000010000000,
        S_FETCH   = 13'b0000100000000,
        S_PWAIT   = 13'b0001000000000,
        S_CMP     = 13'b0010000000000,
        S_DIV     = 13'b0100000000000,
        S_RES     = 13'b1000000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [IW-1:0]        i_reg, i_next;
    logic [HB-1:0]        sb_reg, sb_next;
    logic [JW-1:0]        sq_reg, sq_next;
    logic [JW-1:0]        j_reg, j_next;
    logic [JW-1:0]        j_sum;
    logic [TW-1:0]        total_reg, total_next;
    logic [TW-1:0]        idx_reg, idx_next;
    logic [COUNT_W-1:0]   n_reg, n_next;
    value_t               rem_reg, rem_next;
    value_t               p_reg, p_next;
    logic                 big_reg, big_next;
    logic [15:0]          psq_reg, psq_next;
    logic                 ov_reg, ov_next;
    factor_t              of_reg, of_next;
    logic                 ol_reg, ol_next;
    logic                 oi_reg, oi_next;

    logic                 map_we;
    logic [VALUE_BITS-1:0] map_addr;
    logic                 map_wdata;
    logic                 map_rdata;
    logic                 tab_we;
    logic [VALUE_BITS-1:0] tab_wdata;
    logic [AW-1:0]        tab_raddr;
    logic [VALUE_BITS-1:0] tab_rdata;

    div_req_t             dreq;
    div_rsp_t             drsp;
    logic                 out_free;
    logic                 fin;

    spf_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_addr),
        .wdata (map_wdata),
        .raddr (map_addr),
        .rdata (map_rdata)
    );

    spf_ram #(.WIDTH(VALUE_BITS), .DEPTH(PRIME_SLOTS)) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (total_reg[AW-1:0]),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    spf_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign out_free      = !ov_reg || results.ready;
    assign items.ready   = (state_reg == S_IDLE);
    assign results.valid   = ov_reg;
    assign results.factor  = of_reg;
    assign results.last    = ol_reg;
    assign results.invalid = oi_reg;
    assign j_sum         = j_reg + JW'(sb_reg);
    assign tab_wdata     = i_reg[VALUE_BITS-1:0];
    assign tab_raddr     = idx_reg[AW-1:0];
    assign fin           = (drsp.quotient == value_t'(1)) ||
                           (n_reg == COUNT_W'(MAX_RESULTS - 1));

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        sb_next    = sb_reg;
        sq_next    = sq_reg;
        j_next     = j_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        rem_next   = rem_reg;
        p_next     = p_reg;
        big_next   = big_reg;
        psq_next   = psq_reg;
        ov_next    = ov_reg && !results.ready;
        of_next    = of_reg;
        ol_next    = ol_reg;
        oi_next    = oi_reg;
        map_we     = 1'b0;
        map_addr   = i_reg[VALUE_BITS-1:0];
        map_wdata  = 1'b1;
        tab_we     = 1'b0;
        dreq       = '{start: 1'b0, dividend: rem_reg, divisor: p_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                map_we    = 1'b1;
                map_wdata = (i_reg < IW'(2));
                i_next    = i_reg + 1'b1;
                if (i_reg == IW'(MAP_DEPTH - 1))
                begin
                    sb_next    = HB'(2);
                    state_next = S_SV_SQ;
                end
            end
            S_SV_SQ:
            begin
                map_addr   = VALUE_BITS'(sb_reg);
                sq_next    = JW'(sb_reg) * JW'(sb_reg);
                state_next = S_SV_TEST;
            end
            S_SV_TEST:
            begin
                if ((sq_reg >> VALUE_BITS) != '0)
                begin
                    i_next     = IW'(2);
                    total_next = '0;
                    state_next = S_CL_RD;
                end
                else if (map_rdata)
                begin
                    sb_next    = sb_reg + 1'b1;
                    state_next = S_SV_SQ;
                end
                else
                begin
                    j_next     = sq_reg;
                    state_next = S_SV_MARK;
                end
            end
            S_SV_MARK:
            begin
                map_addr = j_reg[VALUE_BITS-1:0];
                map_we   = 1'b1;
                j_next   = j_sum;
                if ((j_sum >> VALUE_BITS) != '0)
                begin
                    sb_next    = sb_reg + 1'b1;
                    state_next = S_SV_SQ;
                end
            end
            S_CL_RD:
            begin
                state_next = S_CL_TEST;
            end
            S_CL_TEST:
            begin
                if (!map_rdata && total_reg < TW'(PRIME_SLOTS))
                begin
                    tab_we     = 1'b1;
                    total_next = total_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_CL_RD;
                if (i_reg == IW'(MAP_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (items.valid)
                begin
                    rem_next   = items.value;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                idx_next = '0;
                n_next   = '0;
                if (rem_reg >= value_t'(2))
                begin
                    state_next = S_FETCH;
                end
                else if (out_free)
                begin
                    ov_next    = 1'b1;
                    of_next    = '0;
                    ol_next    = 1'b1;
                    oi_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                if (idx_reg >= total_reg)
                begin
                    // table exhausted: what is left goes out unchecked
                    if (out_free)
                    begin
                        ov_next    = 1'b1;
                        of_next    = rem_reg;
                        ol_next    = 1'b1;
                        oi_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_PWAIT;
                end
            end
            S_PWAIT:
            begin
                // any prime above 255 squares past every 16-bit value
                big_next   = (tab_rdata >> 8) != '0;
                psq_next   = 16'(tab_rdata[7:0]) * 16'(tab_rdata[7:0]);
                p_next     = value_t'(tab_rdata);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (big_reg || psq_reg > rem_reg)
                begin
                    if (out_free)
                    begin
                        ov_next    = 1'b1;
                        of_next    = rem_reg;
                        ol_next    = 1'b1;
                        oi_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    dreq.start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                if (drsp.remainder != '0)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FETCH;
                end
                else if (out_free)
                begin
                    ov_next    = 1'b1;
                    of_next    = p_reg;
                    ol_next    = fin;
                    oi_next    = 1'b0;
                    rem_next   = drsp.quotient;
                    n_next     = n_reg + 1'b1;
                    state_next = fin ? S_IDLE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            i_reg     <= '0;
            sb_reg    <= '0;
            total_reg <= '0;
            idx_reg   <= '0;
            n_reg     <= '0;
            rem_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            sb_reg    <= sb_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            rem_reg   <= rem_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg  <= sq_next;
        j_reg   <= j_next;
        p_reg   <= p_next;
        big_reg <= big_next;
        psq_reg <= psq_next;
        of_reg  <= of_next;
        ol_reg  <= ol_next;
        oi_reg  <= oi_next;
    end

endmodule

@@ test/tb_sieve_prime_factorizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sieve_prime_factorizer_core
// self-checking bench for the sieve prime factorizer
// ----------------------------------------------------------------------------
// Builds its own prime table at time zero and factors every accepted request
// by trial division. Each result leaving the block is compared field by
// field with the oldest predicted factor. Directed values cover the edges
// and the special cases, then random values follow with random stalls on
// both channels, one long back-pressure stretch, one idle-free burst and one drain pause.
// ----------------------------------------------------------------------------
module tb_sieve_prime_factorizer_core;
    import spf_pkg::*;

    typedef struct {
        factor_t factor;
        logic    last;
        logic    invalid;
    } factor_rec_t;

    logic clk;
    logic rst_n;

    spf_in_if  items ();
    spf_out_if results ();

    sieve_prime_factorizer_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source)
    );

    bit          composite [65536];
    int unsigned prime_list [$];
    factor_rec_t factor_q [$];

    int errors        = 0;
    int requests_sent = 0;
    int factors_seen  = 0;
    int hold_left     = 0;
    bit quiet         = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void build_prime_table();
        int unsigned i;
        int unsigned j;
        composite[0] = 1;
        composite[1] = 1;
        for (i = 2; i * i < 65536; i++)
        begin
            if (!composite[i])
                for (j = i * i; j < 65536; j += i)
                    composite[j] = 1;
        end
        for (i = 2; i < 65536; i++)
            if (!composite[i] && prime_list.size() < PRIME_SLOTS_DEF)
                prime_list.insert(prime_list.size(), i);
    endfunction

    // trial division, smallest prime first, ascending factors with repeats
    function automatic void predict_factors(input value_t v);
        int unsigned rem;
        int unsigned p;
        int          idx;
        int          n;
        factor_rec_t r;
        rem = v;
        idx = 0;
        n   = 0;
        if (rem < 2)
        begin
            r.factor = '0; r.last = 1'b1; r.invalid = 1'b1;
            factor_q.insert(factor_q.size(), r);
            return;
        end
        while (rem > 1 && n < MAX_RESULTS)
        begin
            r.invalid = 1'b0;
            if (idx >= prime_list.size())
            begin
                r.factor = factor_t'(rem); r.last = 1'b1;
                factor_q.insert(factor_q.size(), r);
                break;
            end
            p = prime_list[idx];
            if (p * p > rem)
            begin
                r.factor = factor_t'(rem); r.last = 1'b1;
                factor_q.insert(factor_q.size(), r);
                break;
            end
            if (rem % p == 0)
            begin
                rem = rem / p;
                n++;
                r.factor = factor_t'(p);
                r.last   = (rem == 1 || n == MAX_RESULTS);
                factor_q.insert(factor_q.size(), r);
            end
            else
                idx++;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // one request; valid is only lowered while idling so it never toggles in a step
    task automatic send_value(input value_t v);
        while (!quiet && $urandom_range(99) < 12)
        begin
            items.valid <= 1'b0;
            @(posedge clk);
        end
        items.valid <= 1'b1;
        items.value <= v;
        do
            @(posedge clk);
        while (!items.ready);
        predict_factors(v);
        requests_sent++;
    endtask

    task automatic stop_sending();
        items.valid <= 1'b0;
        @(posedge clk);
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            factors_seen++;
            if (factor_q.size() == 0)
                report_mismatch($sformatf("unexpected factor %0d", results.factor));
            else
            begin
                factor_rec_t e;
                e = factor_q.pop_front();
                if (results.factor !== e.factor)
                    report_mismatch($sformatf("factor %0d, want %0d",
                                              results.factor, e.factor));
                if (results.last !== e.last)
                    report_mismatch($sformatf("last %0b, want %0b on factor %0d",
                                              results.last, e.last, e.factor));
                if (results.invalid !== e.invalid)
                    report_mismatch($sformatf("invalid %0b, want %0b on factor %0d",
                                              results.invalid, e.invalid, e.factor));
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            results.ready <= 1'b0;
        end
        else
            results.ready <= quiet || ($urandom_range(99) >= 12);
    end

    task automatic wait_drained();
        while (factor_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic value_t random_value();
        int unsigned sel;
        int unsigned a;
        sel = $urandom_range(9);
        case (sel)
            0, 1: return value_t'($urandom_range(15));
            2:
            begin
                a = 1 << $urandom_range(15);
                return value_t'(a * $urandom_range(1, 65535 / a));
            end
            3:
            begin
                a = prime_list[$urandom_range(53)];
                return value_t'(a * a * $urandom_range(1, 65535 / (a * a)));
            end
            4: return value_t'(prime_list[$urandom_range(prime_list.size() - 1)]);
            default: return value_t'($urandom_range(65535));
        endcase
    endfunction

    task automatic test_directed();
        value_t vals [$] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd65535,
                             16'd65521, 16'd65534, 16'd32768, 16'd49, 16'd25,
                             16'd63001, 16'd65498, 16'd6, 16'd30030, 16'd4096,
                             16'd3125, 16'd64009, 16'd255, 16'd257, 16'd43690};
        foreach (vals[i])
            send_value(vals[i]);
    endtask

    task automatic test_random(input int count);
        repeat (count)
            send_value(random_value());
    endtask

    task automatic test_no_idle(input int count);
        quiet = 1;
        test_random(count);
        quiet = 0;
    endtask

    task automatic test_back_pressure();
        hold_left = 4000;
        repeat (12)
            send_value(random_value());
    endtask

    task automatic test_drain_pause();
        stop_sending();
        wait_drained();
        test_random(10);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        items.valid   = 1'b0;
        items.value   = '0;
        results.ready = 1'b0;
        build_prime_table();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(40);
        test_back_pressure();
        test_no_idle(30);
        test_drain_pause();
        test_random(30);
        stop_sending();

        wait_drained();
        repeat (200) @(posedge clk);

        $display("covered %0d requests and %0d factors: edges, primes, powers,",
                 requests_sent, factors_seen);
        $display("random values, long back-pressure, drain pause and idle-free bursts");
        if (errors == 0 && factor_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/spf_pkg.sv
rtl/spf_in_if.sv
rtl/spf_out_if.sv
rtl/spf_ram.sv
rtl/spf_divider.sv
rtl/sieve_prime_factorizer_core.sv
test/tb_sieve_prime_factorizer_core.sv
